FILE: hw/rtl/fas_pkg.sv
// Shared types and constants for the frame animation stepper.
// No dependencies; imported by fas_div, frame_animation_stepper and the testbench.
`default_nettype none

package fas_pkg;

  localparam int DIV_W   = 27;
  localparam int DVS_W   = 24;
  localparam int DCNT_W  = $clog2(DIV_W);
  localparam int ACC_W   = 26;
  localparam int FRAME_W = 8;
  localparam int CNT_W   = 9;
  localparam int DELTA_W = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  localparam logic [1:0] MODE_ONCE   = 2'd0;
  localparam logic [1:0] MODE_LOOP   = 2'd1;
  localparam logic [1:0] MODE_BOUNCE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PLAYING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 2'd3;

  localparam logic OP_TICK      = 1'b0;
  localparam logic OP_SET_FRAME = 1'b1;

  localparam logic [DVS_W-1:0] INTERVAL_RST = 24'd1000000;

  typedef struct packed {
    logic                opcode;
    logic [DELTA_W-1:0]  delta_us;
    logic [FRAME_W-1:0]  frame_index;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0]  current_frame;
    logic                reversing;
    logic                advanced;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_DIV2,
    ST_DONE
  } seq_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fas_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on fas_pkg.
`default_nettype none

module fas_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [fas_pkg::DIV_W-1:0] dividend,
  input  wire logic [fas_pkg::DVS_W-1:0] divisor,
  output fas_pkg::div_stat_t             stat,
  output logic [fas_pkg::DIV_W-1:0]      quotient,
  output logic [fas_pkg::DVS_W-1:0]      remainder
);
  import fas_pkg::*;

  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              take;

  always_comb begin
    trial = {rem_r, quo_r[DIV_W-1]};
    diff  = trial - {1'b0, dvs_r};
    take  = (trial >= {1'b0, dvs_r});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = DCNT_W'(DIV_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_W-2:0], take};
      rem_nxt = take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - DCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

FILE: hw/rtl/frame_animation_stepper.sv
// Set-frame and idle ticks go straight to the result; a once-mode tick makes one pass through
// the shared serial divider, a loop/bounce tick two passes (time, then frame wrap).
// Throughput: one item at a time; the next transfer is taken once the result is registered.
// Reset (sync, rst_n low): frame 0, not reversing, accumulator 0, playing 0, mode once,
// interval 1000000 us, frame count 0.
// Depends on fas_pkg and fas_div.
`default_nettype none

module frame_animation_stepper #(
  parameter int MAX_FRAMES = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire fas_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output fas_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fas_pkg::CFG_DAT_W-1:0] cfg_data
);
  import fas_pkg::*;

  localparam int CAP = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;

  logic              playing_r;
  logic [1:0]        mode_r;
  logic [DVS_W-1:0]  interval_r;
  logic [CNT_W-1:0]  fcount_r;

  seq_state_t        state_r, state_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic              back_r, back_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              adv_r, adv_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  div_stat_t         div_stat;
  logic [DIV_W-1:0]  div_quo;
  logic [DVS_W-1:0]  div_rem;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  cnt_m1;
  logic [DVS_W-1:0]  iv_eff;
  logic [ACC_W-1:0]  acc_sum;
  logic [DIV_W-1:0]  frame_ext;
  logic [DIV_W-1:0]  pos;
  logic [CNT_W-1:0]  rem_c;

  fas_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   ((state_r == ST_IDLE) ? iv_eff : {{(DVS_W-CNT_W){1'b0}}, count}),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign count     = (fcount_r > CNT_W'(CAP)) ? CNT_W'(CAP) : fcount_r;
  assign cnt_m1    = count - CNT_W'(1);
  assign iv_eff    = (interval_r == '0) ? DVS_W'(1) : interval_r;
  assign acc_sum   = acc_r + {{(ACC_W-DELTA_W){1'b0}}, in_data.delta_us};
  assign frame_ext = {{(DIV_W-FRAME_W){1'b0}}, frame_r};
  assign pos       = frame_ext + div_quo;
  assign rem_c     = div_rem[CNT_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    frame_nxt     = frame_r;
    back_nxt      = back_r;
    acc_nxt       = acc_r;
    adv_nxt       = adv_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    div_dividend  = pos;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        div_dividend = {1'b0, acc_sum};
        if (in_valid) begin
          adv_nxt   = 1'b0;
          state_nxt = ST_DONE;
          if (in_data.opcode == OP_SET_FRAME) begin
            if ({1'b0, in_data.frame_index} < count) begin
              frame_nxt = in_data.frame_index;
            end
          end else if (playing_r && count > CNT_W'(1)) begin
            div_start = 1'b1;
            state_nxt = ST_DIV1;
          end
        end
      end
      ST_DIV1: begin
        if (div_stat.done) begin
          acc_nxt   = {{(ACC_W-DVS_W){1'b0}}, div_rem};
          state_nxt = ST_DONE;
          if (div_quo != '0) begin
            adv_nxt = 1'b1;
            case (mode_r)
              MODE_ONCE: begin
                if ({1'b0, frame_r} < cnt_m1) begin
                  frame_nxt = (pos >= {{(DIV_W-CNT_W){1'b0}}, count}) ?
                              cnt_m1[FRAME_W-1:0] : pos[FRAME_W-1:0];
                end
              end
              MODE_LOOP: begin
                div_start = 1'b1;
                state_nxt = ST_DIV2;
              end
              MODE_BOUNCE: begin
                div_start = 1'b1;
                state_nxt = ST_DIV2;
                if (back_r) begin
                  if (div_quo > frame_ext) begin
                    div_dividend = div_quo - frame_ext;
                    back_nxt     = 1'b0;
                  end else begin
                    div_dividend = frame_ext - div_quo;
                  end
                end
              end
              default: begin
                state_nxt = ST_DONE;
              end
            endcase
          end
        end
      end
      ST_DIV2: begin
        if (div_stat.done) begin
          state_nxt = ST_DONE;
          if (mode_r == MODE_LOOP) begin
            frame_nxt = rem_c[FRAME_W-1:0];
          end else if (div_quo == '0) begin
            frame_nxt = rem_c[FRAME_W-1:0];
            if (rem_c == cnt_m1) begin
              back_nxt = 1'b1;
            end
          end else begin
            if (back_r ^ div_quo[0]) begin
              back_nxt  = 1'b1;
              frame_nxt = FRAME_W'(cnt_m1 - rem_c);
            end else begin
              back_nxt  = 1'b0;
              frame_nxt = rem_c[FRAME_W-1:0];
            end
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.current_frame = frame_r;
          out_data_nxt.reversing     = back_r;
          out_data_nxt.advanced      = adv_r;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    adv_r      <= adv_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      frame_r     <= '0;
      back_r      <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      playing_r   <= 1'b0;
      mode_r      <= MODE_ONCE;
      interval_r  <= INTERVAL_RST;
      fcount_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      frame_r     <= frame_nxt;
      back_r      <= back_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_PLAYING:  playing_r  <= cfg_data[0];
          REG_MODE:     mode_r     <= cfg_data[1:0];
          REG_INTERVAL: interval_r <= cfg_data;
          REG_COUNT:    fcount_r   <= cfg_data[CNT_W-1:0];
          default:      fcount_r   <= fcount_r;
        endcase
      end
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

FILE: tb/sv/tb_frame_animation_stepper.sv
// Testbench for frame_animation_stepper: directed and random tick/set-frame transfers
// under random valid/stall gaps, checked against a frame tracker held in a small class.
// Depends on fas_pkg and the frame_animation_stepper RTL.
`timescale 1ns / 1ps

module tb_frame_animation_stepper;
  import fas_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1600;
  localparam int HOLD_CYCLES = 400;

  class frame_tracker;
    logic        playing;
    logic [1:0]  mode;
    logic [23:0] interval;
    logic [8:0]  fcount;
    logic [7:0]  frame;
    logic        back;
    logic [25:0] accum;
    out_item_t   frames_due[$];
    int          mismatches;

    function new();
      playing    = 1'b0;
      mode       = MODE_ONCE;
      interval   = INTERVAL_RST;
      fcount     = '0;
      frame      = '0;
      back       = 1'b0;
      accum      = '0;
      mismatches = 0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        REG_PLAYING:  playing  = val[0];
        REG_MODE:     mode     = val[1:0];
        REG_INTERVAL: interval = val[23:0];
        REG_COUNT:    fcount   = val[8:0];
        default: ;
      endcase
    endfunction

    function void step_animation(in_item_t it);
      out_item_t want;
      longint    cnt, iv, steps, pos, n, q;
      logic      adv;
      cnt = (fcount > 9'd256) ? 256 : longint'(fcount);
      adv = 1'b0;
      if (it.opcode == OP_SET_FRAME) begin
        if (it.frame_index < cnt) frame = it.frame_index;
      end else if (playing && cnt > 1) begin
        iv = (interval == 0) ? 1 : longint'(interval);
        accum = accum + it.delta_us;
        if (accum >= iv) begin
          steps = accum / iv;
          accum = 26'(accum % iv);
          adv = 1'b1;
          case (mode)
            MODE_ONCE: begin
              if (frame < cnt - 1) begin
                pos = longint'(frame) + steps;
                if (pos >= cnt) pos = cnt - 1;
                frame = pos[7:0];
              end
            end
            MODE_LOOP: begin
              pos = longint'(frame) + steps;
              if (pos >= cnt) pos = pos % cnt;
              frame = pos[7:0];
            end
            MODE_BOUNCE: begin
              n = back ? longint'(frame) - steps : longint'(frame) + steps;
              if (n < 0) begin
                n = -n;
                back = 1'b0;
              end
              if (n >= cnt) begin
                q = n / cnt;
                n = n % cnt;
                if (q[0]) back = ~back;
                frame = back ? 8'(cnt - 1 - n) : n[7:0];
              end else begin
                frame = n[7:0];
                if (n == cnt - 1) back = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      want.current_frame = frame;
      want.reversing     = back;
      want.advanced      = adv;
      frames_due.push_back(want);
    endfunction

    function void check_frame(out_item_t got);
      out_item_t want;
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual frame %0d rev %0b adv %0b",
                 $time, got.current_frame, got.reversing, got.advanced);
        mismatches++;
        return;
      end
      want = frames_due.pop_front();
      if (got.current_frame !== want.current_frame) begin
        $display("%0t: current_frame expected %0d actual %0d",
                 $time, want.current_frame, got.current_frame);
        mismatches++;
      end
      if (got.reversing !== want.reversing) begin
        $display("%0t: reversing expected %0b actual %0b", $time, want.reversing, got.reversing);
        mismatches++;
      end
      if (got.advanced !== want.advanced) begin
        $display("%0t: advanced expected %0b actual %0b", $time, want.advanced, got.advanced);
        mismatches++;
      end
    endfunction

    function int pending();
      return frames_due.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  frame_tracker tracker;
  bit           no_gaps;
  int           hold_seq;

  frame_animation_stepper u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_frame(out_data);
  end

  // result side: random stall runs, plus a long hold-off on request
  initial begin : result_sink
    int stall_left;
    int hold_seen;
    stall_left = 0;
    hold_seen  = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        if (stall_left == 0 && !no_gaps && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  task automatic send_item(input logic op, input logic [19:0] delta, input logic [7:0] idx);
    in_item_t it;
    int       gap;
    it.opcode      = op;
    it.delta_us    = delta;
    it.frame_index = idx;
    gap = no_gaps ? 0 : pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    tracker.step_animation(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.note_config(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic config_all(input logic [23:0] ply, input logic [23:0] mode,
                            input logic [23:0] iv, input logic [23:0] cnt);
    drain();
    write_reg(REG_PLAYING, ply);
    write_reg(REG_MODE, mode);
    write_reg(REG_INTERVAL, iv);
    write_reg(REG_COUNT, cnt);
  endtask

  task automatic random_phase(input int k, input bit hold, output int useful);
    logic [23:0] junk;
    logic        ply;
    logic [1:0]  mode;
    logic [23:0] iv;
    logic [8:0]  cnt;
    logic        op;
    logic [19:0] delta;
    logic [7:0]  idx;
    int          eff, ivx, r;
    junk = 24'($urandom);
    ply  = ($urandom_range(0, 9) != 0);
    r = $urandom_range(0, 9);
    mode = (r < 3) ? MODE_ONCE : (r < 6) ? MODE_LOOP : (r < 9) ? MODE_BOUNCE : MODE_UNUSED;
    r = $urandom_range(0, 9);
    case (r)
      0: iv = '0;
      1: iv = 24'd1;
      2, 3: iv = 24'($urandom_range(2, 16));
      4, 5: iv = 24'($urandom_range(17, 1000));
      6, 7: iv = 24'($urandom_range(1001, 300000));
      8: iv = 24'hFFFFFF;
      default: iv = 24'($urandom_range(300001, 24'hFFFFFF));
    endcase
    r = $urandom_range(0, 11);
    case (r)
      0: cnt = 9'($urandom_range(0, 1));
      1: cnt = 9'd2;
      2: cnt = 9'd3;
      3, 4, 5, 6: cnt = 9'($urandom_range(4, 16));
      7, 8: cnt = 9'($urandom_range(17, 255));
      9: cnt = 9'd256;
      10: cnt = 9'($urandom_range(257, 511));
      default: cnt = 9'd255;
    endcase
    config_all({junk[23:1], ply}, {junk[23:2], mode}, iv, {junk[23:9], cnt});
    if (hold) hold_seq++;
    eff = (cnt > 9'd256) ? 256 : int'(cnt);
    ivx = (iv == 0) ? 1 : int'(iv);
    useful = 0;
    repeat (k) begin
      op = ($urandom_range(0, 99) < 15) ? OP_SET_FRAME : OP_TICK;
      idx = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, (eff == 0) ? 0 : eff - 1))
                                        : 8'($urandom);
      r = $urandom_range(0, 9);
      case (r)
        0: delta = '0;
        1: delta = 20'hFFFFF;
        2, 3: delta = 20'($urandom);
        default: delta = 20'($urandom_range(0, (3 * ivx < 20'hFFFFF) ? 3 * ivx : 20'hFFFFF));
      endcase
      if (op == OP_SET_FRAME ? (idx < eff) : (ply && eff > 1)) useful++;
      send_item(op, delta, idx);
    end
  endtask

  initial begin : stimulus
    int phase_no;
    int useful_total;
    int useful;
    tracker   = new();
    no_gaps   = 1'b0;
    hold_seq  = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: not playing, no frames
    send_item(OP_TICK, 20'd5, 8'd0);
    send_item(OP_SET_FRAME, 20'd0, 8'd0);

    config_all(24'd1, 24'(MODE_ONCE), 24'd10, 24'd4);
    send_item(OP_TICK, 20'd9, 8'd0);
    send_item(OP_TICK, 20'd1, 8'd0);
    send_item(OP_TICK, 20'hFFFFF, 8'd0);
    send_item(OP_TICK, 20'd10, 8'd0);
    send_item(OP_SET_FRAME, 20'hFFFFF, 8'd2);
    send_item(OP_SET_FRAME, 20'd0, 8'd4);
    send_item(OP_TICK, 20'd0, 8'hFF);

    // zero interval acts as one, upper data bits masked
    config_all(24'hFFFFFF, 24'(MODE_LOOP), 24'd0, 24'd5);
    send_item(OP_TICK, 20'd7, 8'd0);
    send_item(OP_TICK, 20'hFFFFF, 8'd0);
    send_item(OP_SET_FRAME, 20'd0, 8'd255);

    config_all(24'd1, 24'(MODE_BOUNCE), 24'd1, 24'd5);
    send_item(OP_SET_FRAME, 20'd0, 8'd0);
    send_item(OP_TICK, 20'd4, 8'd0);
    send_item(OP_TICK, 20'd6, 8'd0);
    send_item(OP_TICK, 20'd13, 8'd0);
    send_item(OP_TICK, 20'd4, 8'd0);
    send_item(OP_TICK, 20'hFFFFF, 8'd0);

    config_all(24'd1, 24'(MODE_UNUSED), 24'd1, 24'd5);
    send_item(OP_TICK, 20'd3, 8'd0);

    // count field saturates at 256 frames
    config_all(24'd1, 24'(MODE_LOOP), 24'd1, 24'hFFFFFF);
    send_item(OP_SET_FRAME, 20'd0, 8'd255);
    send_item(OP_TICK, 20'd1, 8'd0);
    send_item(OP_SET_FRAME, 20'd0, 8'd200);

    // frame beyond a shrunk count
    config_all(24'd1, 24'(MODE_LOOP), 24'd3, 24'd7);
    send_item(OP_TICK, 20'd9, 8'd0);

    config_all(24'd1, 24'(MODE_ONCE), 24'd1, 24'd1);
    send_item(OP_TICK, 20'd5, 8'd0);
    config_all(24'hFFFFFE, 24'(MODE_ONCE), 24'd1, 24'd7);
    send_item(OP_TICK, 20'd5, 8'd0);

    phase_no     = 0;
    useful_total = 0;
    while (useful_total < ITEM_TARGET) begin
      no_gaps = (phase_no % 5 == 4);
      random_phase($urandom_range(40, 120), phase_no == 2 || phase_no == 9, useful);
      useful_total += useful;
      phase_no++;
    end
    no_gaps = 1'b0;

    drain();
    repeat (100) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
